// ===== src/v3alu_pkg.sv =====
// v3alu_pkg: shared types and constants for the three-component vector unit.
// Holds the operation and status codes and the default pipeline parameters.
// No dependencies.
package v3alu_pkg;

  // Default number format: signed Q16.16 results saturated to 32 bits
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned WORD_BITS_DEF = 32;

  // Width of every vector component and scalar on the ports
  localparam int unsigned IN_W = 32;

  // Operation codes
  typedef enum logic [3:0] {
    OpAdd       = 4'd0,
    OpSub       = 4'd1,
    OpNeg       = 4'd2,
    OpScale     = 4'd3,
    OpDiv       = 4'd4,
    OpDot       = 4'd5,
    OpLength    = 4'd6,
    OpNormalize = 4'd7,
    OpCross     = 4'd8,
    OpProject   = 4'd9,
    OpReject    = 4'd10
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StDivZero = 2'd1,
    StSat     = 2'd2
  } status_e;

endpackage

// ===== src/vector3_alu_top.sv =====
// vector3_alu_top: fully pipelined three-component vector unit in signed fixed point.
// Depends on v3alu_pkg for operation/status codes and default parameters.
//
// Usage
//   Drive operation_i, a_*_i, b_*_i and scale_factor_i and raise start_i for one
//   cycle; the transfer happens at that rising edge. busy_o never rises, so a
//   new item may be started in every cycle.
//   Each result appears on r_x_o, r_y_o, r_z_o, scalar_out_o and status_o for
//   exactly one cycle with valid_o high, in the order the items were started.
//   The receiver cannot hold results off and none is needed.
// Latency and throughput
//   One item per cycle. valid_o rises once the item has crossed the stage-0
//   capture, multiply, round, dot, partial-product and combine stages, the 32-step
//   square-root pipeline for length/normalize, the divider set-up stage, the
//   one-bit-per-stage restoring divider shared by divide, normalize, project
//   and reject, which every item passes through, and the output register; the
//   result transfer happens at the edge after that.
// Reset
//   rst_ni clears all valid bits at once; items in flight are dropped and no
//   result is strobed until a new item has crossed the pipeline.
module vector3_alu_top
  import v3alu_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [3:0]             operation_i,
  input  logic signed [IN_W-1:0] a_x_i,
  input  logic signed [IN_W-1:0] a_y_i,
  input  logic signed [IN_W-1:0] a_z_i,
  input  logic signed [IN_W-1:0] b_x_i,
  input  logic signed [IN_W-1:0] b_y_i,
  input  logic signed [IN_W-1:0] b_z_i,
  input  logic signed [IN_W-1:0] scale_factor_i,
  output logic                   valid_o,
  output logic signed [IN_W-1:0] r_x_o,
  output logic signed [IN_W-1:0] r_y_o,
  output logic signed [IN_W-1:0] r_z_o,
  output logic signed [IN_W-1:0] scalar_out_o,
  output logic [1:0]             status_o
);

  // Datapath widths
  localparam int unsigned IW    = IN_W;
  localparam int unsigned PW    = 2 * IW;               // full product
  localparam int unsigned RND_W = PW - FRAC_BITS;       // rounded product
  localparam int unsigned DOT_W = RND_W + 2;            // sum of three
  localparam int unsigned MAG_W = RND_W;                // |dot| magnitude
  localparam int unsigned HI_W  = MAG_W - IW;
  localparam int unsigned PH_W  = IW + HI_W;
  localparam int unsigned NUM_W = IW + MAG_W;           // dividend
  localparam int unsigned DIV_W = MAG_W;                // divisor
  localparam int unsigned QW    = ((WORD_BITS > IW) ? WORD_BITS : IW) + 1;
  localparam int unsigned TOP_W = NUM_W - QW;
  localparam int unsigned CW    = (TOP_W > DIV_W) ? TOP_W : DIV_W;
  localparam int unsigned EXT_W = (((QW + 3) > DOT_W) ? (QW + 3) : DOT_W) + 1;
  localparam int unsigned SQ_N  = IW;                   // root bits
  localparam int unsigned KS    = 6 + SQ_N;             // divider set-up stage
  localparam int unsigned NST   = KS + 1 + QW;          // pipeline registers

  localparam logic signed [PW-1:0]    RND_HALF = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [EXT_W-1:0] HI_LIM   =
    {{(EXT_W - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
  localparam logic signed [EXT_W-1:0] LO_LIM   = ~HI_LIM;

  // One pipeline slot; each stage fills the fields it owns
  typedef struct packed {
    op_e                      op;
    logic [2:0][IW-1:0]       a;
    logic [2:0][IW-1:0]       b;
    logic [IW-1:0]            s;
    logic [5:0][PW-1:0]       prod;
    logic [5:0][RND_W-1:0]    rnd;
    logic [PW-1:0]            sq_x;
    logic [PW-1:0]            sq_r;
    logic [2:0][EXT_W-1:0]    vec;
    logic [EXT_W-1:0]         scl;
    logic [DOT_W-1:0]         dab;
    logic [DOT_W-1:0]         dbb;
    logic [2:0][PW-1:0]       pp_lo;
    logic [2:0][PH_W-1:0]     pp_hi;
    logic [2:0][NUM_W-1:0]    num;
    logic [DIV_W-1:0]         dvs;
    logic [2:0]               neg;
    logic                     dz;
    logic [2:0]               ovf;
    logic [2:0][DIV_W-1:0]    rem;
    logic [2:0][QW-1:0]       quo;
    logic [2:0][QW-1:0]       nlo;
  } pipe_t;

  pipe_t             pipe_d [NST];
  pipe_t             pipe_q [NST];
  logic [NST-1:0]    vld_q;

  logic [5:0][IW-1:0] mul_x, mul_y;
  logic [DOT_W-1:0]   st3_dab, st3_dbb, dab_abs;
  logic [2:0][IW-1:0] b_abs, a_abs;
  logic [IW-1:0]      s_abs, sqrt_len;
  logic [2:0][CW-1:0] top_ext;
  logic [PW:0]        sq_sum [SQ_N];
  logic [2:0][DIV_W:0] dv_t [QW];

  logic [2:0][QW:0]       qmag;
  logic [2:0][EXT_W-1:0]  pq, vfin;
  logic [EXT_W-1:0]       sfin;
  logic [3:0][IW:0]       clamp_r;
  logic [2:0][IW-1:0]     r_d, r_q;
  logic [IW-1:0]          scl_d, scl_q;
  status_e                st_d, st_q;
  logic                   valid_q;

  // Saturate to the signed WORD_BITS range; top bit flags a clamp
  function automatic logic [IW:0] clamp_w(input logic [EXT_W-1:0] v);
    logic [IW:0] res;
    if ($signed(v) > HI_LIM) begin
      res = {1'b1, HI_LIM[IW-1:0]};
    end else if ($signed(v) < LO_LIM) begin
      res = {1'b1, LO_LIM[IW-1:0]};
    end else begin
      res = {1'b0, v[IW-1:0]};
    end
    return res;
  endfunction

  assign busy_o = 1'b0;

  // Stage 0: capture the transfer
  always_comb begin
    pipe_d[0]      = '0;
    pipe_d[0].op   = op_e'(operation_i);
    pipe_d[0].a    = {a_z_i, a_y_i, a_x_i};
    pipe_d[0].b    = {b_z_i, b_y_i, b_x_i};
    pipe_d[0].s    = scale_factor_i;
  end

  // Stage 1: six signed multipliers, operands chosen by operation
  always_comb begin
    pipe_d[1] = pipe_q[0];
    for (int i = 0; i < 3; i++) begin
      mul_x[i]     = pipe_q[0].a[i];
      mul_y[i]     = pipe_q[0].b[i];
      mul_x[i + 3] = pipe_q[0].b[i];
      mul_y[i + 3] = pipe_q[0].b[i];
    end
    unique case (pipe_q[0].op)
      OpCross: begin
        mul_x[0] = pipe_q[0].a[1]; mul_y[0] = pipe_q[0].b[2];
        mul_x[3] = pipe_q[0].a[2]; mul_y[3] = pipe_q[0].b[1];
        mul_x[1] = pipe_q[0].a[2]; mul_y[1] = pipe_q[0].b[0];
        mul_x[4] = pipe_q[0].a[0]; mul_y[4] = pipe_q[0].b[2];
        mul_x[2] = pipe_q[0].a[0]; mul_y[2] = pipe_q[0].b[1];
        mul_x[5] = pipe_q[0].a[1]; mul_y[5] = pipe_q[0].b[0];
      end
      OpScale: begin
        for (int i = 0; i < 3; i++) mul_y[i] = pipe_q[0].s;
      end
      OpLength, OpNormalize: begin
        for (int i = 0; i < 3; i++) mul_y[i] = pipe_q[0].a[i];
      end
      default: ;
    endcase
    for (int k = 0; k < 6; k++) begin
      pipe_d[1].prod[k] = PW'($signed(mul_x[k])) * PW'($signed(mul_y[k]));
    end
  end

  // Stage 2: round half up to Q format; exact sum of squares
  always_comb begin
    pipe_d[2] = pipe_q[1];
    for (int k = 0; k < 6; k++) begin
      pipe_d[2].rnd[k] = RND_W'(($signed(pipe_q[1].prod[k]) + RND_HALF) >>> FRAC_BITS);
    end
    pipe_d[2].sq_x = pipe_q[1].prod[0] + pipe_q[1].prod[1] + pipe_q[1].prod[2];
    pipe_d[2].sq_r = '0;
  end

  // Stage 3: dot sums and the simple vector results
  always_comb begin
    pipe_d[3] = pipe_q[2];
    st3_dab = DOT_W'($signed(pipe_q[2].rnd[0])) + DOT_W'($signed(pipe_q[2].rnd[1]))
            + DOT_W'($signed(pipe_q[2].rnd[2]));
    st3_dbb = DOT_W'($signed(pipe_q[2].rnd[3])) + DOT_W'($signed(pipe_q[2].rnd[4]))
            + DOT_W'($signed(pipe_q[2].rnd[5]));
    pipe_d[3].dab = st3_dab;
    pipe_d[3].dbb = st3_dbb;
    pipe_d[3].vec = '0;
    pipe_d[3].scl = '0;
    for (int i = 0; i < 3; i++) begin
      unique case (pipe_q[2].op)
        OpAdd:   pipe_d[3].vec[i] = EXT_W'($signed(pipe_q[2].a[i]))
                                  + EXT_W'($signed(pipe_q[2].b[i]));
        OpSub:   pipe_d[3].vec[i] = EXT_W'($signed(pipe_q[2].a[i]))
                                  - EXT_W'($signed(pipe_q[2].b[i]));
        OpNeg:   pipe_d[3].vec[i] = EXT_W'(0) - EXT_W'($signed(pipe_q[2].a[i]));
        OpScale: pipe_d[3].vec[i] = EXT_W'($signed(pipe_q[2].rnd[i]));
        OpCross: pipe_d[3].vec[i] = EXT_W'($signed(pipe_q[2].rnd[i]))
                                  - EXT_W'($signed(pipe_q[2].rnd[i + 3]));
        default: ;
      endcase
    end
    if (pipe_q[2].op == OpDot) begin
      pipe_d[3].scl = EXT_W'($signed(st3_dab));
    end
  end

  // Stage 4: |b| * |dot(a,b)| split into two partial products
  always_comb begin
    pipe_d[4] = pipe_q[3];
    dab_abs = pipe_q[3].dab[DOT_W-1] ? (~pipe_q[3].dab + 1'b1) : pipe_q[3].dab;
    for (int i = 0; i < 3; i++) begin
      b_abs[i] = pipe_q[3].b[i][IW-1] ? (~pipe_q[3].b[i] + 1'b1) : pipe_q[3].b[i];
      pipe_d[4].pp_lo[i] = PW'(b_abs[i]) * PW'(dab_abs[IW-1:0]);
      pipe_d[4].pp_hi[i] = PH_W'(b_abs[i]) * PH_W'(dab_abs[MAG_W-1:IW]);
    end
  end

  // Stage 5: combine partial products into the projection dividend
  always_comb begin
    pipe_d[5] = pipe_q[4];
    for (int i = 0; i < 3; i++) begin
      pipe_d[5].num[i] = NUM_W'(pipe_q[4].pp_lo[i]) + (NUM_W'(pipe_q[4].pp_hi[i]) << IW);
    end
  end

  // Square root: one result bit per stage, floor(sqrt(sum of squares))
  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    localparam int unsigned SH = 2 * (SQ_N - 1 - j);
    always_comb begin
      pipe_d[6 + j] = pipe_q[5 + j];
      sq_sum[j] = {1'b0, pipe_q[5 + j].sq_r} + ((PW + 1)'(1) << SH);
      if ({1'b0, pipe_q[5 + j].sq_x} >= sq_sum[j]) begin
        pipe_d[6 + j].sq_x = PW'({1'b0, pipe_q[5 + j].sq_x} - sq_sum[j]);
        pipe_d[6 + j].sq_r = (pipe_q[5 + j].sq_r >> 1) + (PW'(1) << SH);
      end else begin
        pipe_d[6 + j].sq_r = pipe_q[5 + j].sq_r >> 1;
      end
    end
  end

  // Divider set-up: pick dividend, divisor and sign; check quotient range
  always_comb begin
    pipe_d[KS] = pipe_q[KS-1];
    sqrt_len = pipe_q[KS-1].sq_r[IW-1:0];
    s_abs = pipe_q[KS-1].s[IW-1] ? (~pipe_q[KS-1].s + 1'b1) : pipe_q[KS-1].s;
    for (int i = 0; i < 3; i++) begin
      a_abs[i] = pipe_q[KS-1].a[i][IW-1] ? (~pipe_q[KS-1].a[i] + 1'b1)
                                         : pipe_q[KS-1].a[i];
    end
    pipe_d[KS].dz  = 1'b0;
    pipe_d[KS].neg = '0;
    pipe_d[KS].dvs = pipe_q[KS-1].dbb[DIV_W-1:0];
    unique case (pipe_q[KS-1].op)
      OpDiv: begin
        pipe_d[KS].dvs = DIV_W'(s_abs);
        pipe_d[KS].dz  = (pipe_q[KS-1].s == '0);
        for (int i = 0; i < 3; i++) begin
          pipe_d[KS].num[i] = NUM_W'(a_abs[i]) << FRAC_BITS;
          pipe_d[KS].neg[i] = pipe_q[KS-1].a[i][IW-1] ^ pipe_q[KS-1].s[IW-1];
        end
      end
      OpLength: pipe_d[KS].scl = EXT_W'(sqrt_len);
      OpNormalize: begin
        pipe_d[KS].dvs = DIV_W'(sqrt_len);
        pipe_d[KS].dz  = (sqrt_len == '0);
        for (int i = 0; i < 3; i++) begin
          pipe_d[KS].num[i] = NUM_W'(a_abs[i]) << FRAC_BITS;
          pipe_d[KS].neg[i] = pipe_q[KS-1].a[i][IW-1];
        end
      end
      OpProject, OpReject: begin
        pipe_d[KS].dz = pipe_q[KS-1].dbb[DOT_W-1] | (pipe_q[KS-1].dbb == '0);
        for (int i = 0; i < 3; i++) begin
          pipe_d[KS].neg[i] = pipe_q[KS-1].b[i][IW-1] ^ pipe_q[KS-1].dab[DOT_W-1];
        end
      end
      default: ;
    endcase
    // quotient of more than QW bits saturates anyway; flag it up front
    for (int i = 0; i < 3; i++) begin
      top_ext[i]         = CW'(pipe_d[KS].num[i][NUM_W-1:QW]);
      pipe_d[KS].ovf[i]  = (top_ext[i] >= CW'(pipe_d[KS].dvs));
      pipe_d[KS].rem[i]  = DIV_W'(top_ext[i]);
      pipe_d[KS].nlo[i]  = pipe_d[KS].num[i][QW-1:0];
      pipe_d[KS].quo[i]  = '0;
    end
  end

  // Restoring divider: one quotient bit per stage on each lane
  for (genvar j = 0; j < QW; j++) begin : g_div
    always_comb begin
      pipe_d[KS + 1 + j] = pipe_q[KS + j];
      for (int i = 0; i < 3; i++) begin
        dv_t[j][i] = {pipe_q[KS + j].rem[i], pipe_q[KS + j].nlo[i][QW-1]};
        pipe_d[KS + 1 + j].nlo[i] = pipe_q[KS + j].nlo[i] << 1;
        if (dv_t[j][i] >= {1'b0, pipe_q[KS + j].dvs}) begin
          pipe_d[KS + 1 + j].rem[i] = DIV_W'(dv_t[j][i] - {1'b0, pipe_q[KS + j].dvs});
          pipe_d[KS + 1 + j].quo[i] = {pipe_q[KS + j].quo[i][QW-2:0], 1'b1};
        end else begin
          pipe_d[KS + 1 + j].rem[i] = DIV_W'(dv_t[j][i]);
          pipe_d[KS + 1 + j].quo[i] = {pipe_q[KS + j].quo[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  // Pipeline registers: valid bits reset, payload free-running
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NST-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  // Final stage: signed quotient, reject, zeroing and saturation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qmag[i] = pipe_q[NST-1].ovf[i] ? ((QW + 1)'(1) << QW)
                                     : (QW + 1)'(pipe_q[NST-1].quo[i]);
      pq[i]   = pipe_q[NST-1].neg[i] ? (EXT_W'(0) - EXT_W'(qmag[i])) : EXT_W'(qmag[i]);
      unique case (pipe_q[NST-1].op)
        OpDiv, OpNormalize, OpProject: vfin[i] = pq[i];
        OpReject: vfin[i] = EXT_W'($signed(pipe_q[NST-1].a[i])) - pq[i];
        default:  vfin[i] = pipe_q[NST-1].vec[i];
      endcase
    end
    sfin = pipe_q[NST-1].scl;
    if (pipe_q[NST-1].dz) begin
      vfin = '0;
      sfin = '0;
    end
    for (int i = 0; i < 3; i++) begin
      clamp_r[i] = clamp_w(vfin[i]);
      r_d[i]     = clamp_r[i][IW-1:0];
    end
    clamp_r[3] = clamp_w(sfin);
    scl_d      = clamp_r[3][IW-1:0];
    if (pipe_q[NST-1].dz) begin
      st_d = StDivZero;
    end else if (clamp_r[0][IW] | clamp_r[1][IW] | clamp_r[2][IW] | clamp_r[3][IW]) begin
      st_d = StSat;
    end else begin
      st_d = StOk;
    end
  end

  // Output register and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    scl_q <= scl_d;
    st_q  <= st_d;
  end

  assign valid_o      = valid_q;
  assign r_x_o        = r_q[0];
  assign r_y_o        = r_q[1];
  assign r_z_o        = r_q[2];
  assign scalar_out_o = scl_q;
  assign status_o     = st_q;

endmodule
